### rtl/core/dart_pkg.sv
// Shared types, codes and helpers for the divider and reload timer.
// No dependencies; used by dart_core and divider_and_reload_timer.
`default_nettype none

package dart_pkg;

   // Operation codes of a request
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Register select codes
   localparam logic [1:0] REG_DIVIDER = 2'd0;
   localparam logic [1:0] REG_COUNTER = 2'd1;
   localparam logic [1:0] REG_RELOAD  = 2'd2;
   localparam logic [1:0] REG_CONTROL = 2'd3;

   localparam int DIV_WIDTH   = 16;
   localparam int DIV_IDX_W   = 4;
   localparam int DATA_WIDTH  = 8;
   localparam int CTRL_WIDTH  = 3;
   localparam int CTRL_ENABLE = 2;

   // Divider bits 13..6 show on a divider read
   localparam int DIV_READ_LSB = 6;

   // Upper control bits read back as ones
   localparam logic [DATA_WIDTH-CTRL_WIDTH-1:0] CTRL_READ_FILL = '1;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] write_data;
      logic [1:0]            reg_select;
      logic [1:0]            operation;
   } item_type;

   typedef struct packed {
      logic                  timer_irq;
      logic [DATA_WIDTH-1:0] read_data;
   } result_type;

   // Divider bit that clocks the counter for each mode
   function automatic logic [DIV_IDX_W-1:0] mode_bit(input logic [1:0] mode);
      logic [DIV_IDX_W-1:0] idx;
      case (mode)
         2'd0: idx = 4'd7;
         2'd1: idx = 4'd1;
         2'd2: idx = 4'd3;
         2'd3: idx = 4'd5;
         default: idx = 4'd7;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

### rtl/core/dart_core.sv
// Timer state and single-tick update logic of the divider and reload timer.
// Depends on dart_pkg.
`default_nettype none

module dart_core (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  step,
   input  wire  dart_pkg::item_type    item,
   output       dart_pkg::result_type  result
);

   logic [dart_pkg::DIV_WIDTH-1:0]  divider_ff, divider_in;
   logic [dart_pkg::DATA_WIDTH-1:0] count_ff, count_in;
   logic [dart_pkg::DATA_WIDTH-1:0] reload_ff, reload_in;
   logic [dart_pkg::CTRL_WIDTH-1:0] control_ff, control_in;
   logic                            term_ff, term_in;
   logic                            top_ff, top_in;
   logic                            pending_ff, pending_in;

   logic                            wr, rd, count_write, loaded, term;
   logic [dart_pkg::DATA_WIDTH-1:0] count_step;

   always_comb begin
      wr          = (item.operation == dart_pkg::OP_WRITE);
      rd          = (item.operation == dart_pkg::OP_READ);
      count_write = wr && (item.reg_select == dart_pkg::REG_COUNTER);

      reload_in  = (wr && item.reg_select == dart_pkg::REG_RELOAD) ? item.write_data
                                                                     : reload_ff;
      control_in = (wr && item.reg_select == dart_pkg::REG_CONTROL)
                   ? item.write_data[dart_pkg::CTRL_WIDTH-1:0] : control_ff;
      divider_in = (wr && item.reg_select == dart_pkg::REG_DIVIDER)
                   ? '0 : divider_ff + 1'b1;

      loaded = pending_ff || count_write;
      term   = control_in[dart_pkg::CTRL_ENABLE]
               & divider_in[dart_pkg::mode_bit(control_in[1:0])];

      // count on a falling edge of the clock term
      count_step = count_ff + {{(dart_pkg::DATA_WIDTH-1){1'b0}}, (term_ff & ~term)};

      result.timer_irq = 1'b0;
      if (loaded) begin
         count_in         = count_write ? item.write_data : reload_in;
         result.timer_irq = pending_ff;
         pending_in       = 1'b0;
         top_in           = 1'b0;
      end else begin
         count_in   = count_step;
         top_in     = count_step[dart_pkg::DATA_WIDTH-1];
         pending_in = top_ff & ~count_step[dart_pkg::DATA_WIDTH-1];
      end
      term_in = term;

      result.read_data = '0;
      if (rd) begin
         case (item.reg_select)
            dart_pkg::REG_DIVIDER: result.read_data =
               divider_in[dart_pkg::DIV_READ_LSB +: dart_pkg::DATA_WIDTH];
            dart_pkg::REG_COUNTER: result.read_data = count_in;
            dart_pkg::REG_RELOAD:  result.read_data = reload_in;
            default:               result.read_data = {dart_pkg::CTRL_READ_FILL, control_in};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
         count_ff   <= '0;
         reload_ff  <= '0;
         control_ff <= '0;
         term_ff    <= 1'b0;
         top_ff     <= 1'b0;
         pending_ff <= 1'b0;
      end else if (step) begin
         divider_ff <= divider_in;
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         control_ff <= control_in;
         term_ff    <= term_in;
         top_ff     <= top_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/divider_and_reload_timer.sv
// Top level of the divider and reload timer: request register, tick update
// in dart_core, response register. Depends on dart_pkg and dart_core.
//
//  Channel | Dir | Handshake            | Payload
//  req_*   | in  | req_tvalid/tready    | tdata: write_data; tuser: operation, reg_select
//  rsp_*   | out | rsp_tvalid/tready    | tdata: read_data, timer_irq
//
// One request per clock sustained while responses drain; each request is one
// machine cycle of the timer. A request passes the request register, then the
// tick logic into the response register. The tick update (divider increment,
// mode mux, counter add) is the only logic between the two registers.
// Reset clears the timer state and empties both registers.
// A stalled response holds its register and the held request; requests keep
// flowing as long as the response register drains.
`default_nettype none

module divider_and_reload_timer (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output       logic        req_tready,
   input  wire  logic [7:0]  req_tdata,   // [7:0] write_data
   input  wire  logic [3:0]  req_tuser,   // [1:0] operation, [3:2] reg_select
   output       logic        rsp_tvalid,
   input  wire  logic        rsp_tready,
   output       logic [15:0] rsp_tdata    // [7:0] read_data, [8] timer_irq, [15:9] zero
);

   logic                 in_valid_ff, in_valid_in;
   dart_pkg::item_type   in_item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   dart_pkg::result_type rsp_result_ff;
   dart_pkg::result_type core_result;
   logic                 advance, req_fire;

   // advance the held request into the response register when it has room
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: capture request, hold result until taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.write_data <= req_tdata;
         in_item_ff.operation  <= req_tuser[1:0];
         in_item_ff.reg_select <= req_tuser[3:2];
      end
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   dart_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_result_ff.timer_irq, rsp_result_ff.read_data};

endmodule

`default_nettype wire

### rtl/core/dart_checker.sv
// Port-level checks of the divider and reload timer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module dart_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata
);

   logic [1:0] inflight_ff, inflight_in;
   logic       last_irq_ff;
   logic       req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         last_irq_ff <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         if (rsp_fire) begin
            last_irq_ff <= rsp_tdata[8];
         end
      end
   end

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // no more than the two registers hold requests; no response without a request
   a_inflight: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff != 2'd3) && (!rsp_tvalid || inflight_ff != 2'd0))
      else $error("request/response count out of range");

   // a reload needs a counting tick in between, so interrupts never come back to back
   a_irq_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && last_irq_ff |-> !rsp_tdata[8])
      else $error("interrupt on two consecutive responses");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] == 7'd0)
      else $error("response padding not zero");

endmodule

bind divider_and_reload_timer dart_checker u_dart_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/tb_divider_and_reload_timer.sv
// Self-checking testbench for divider_and_reload_timer: drives timer requests,
// predicts each response with a cycle model, and checks them in order.
// Depends on dart_pkg and the divider_and_reload_timer RTL.

// Request code with no defined function; the block treats it as a plain tick
localparam logic [1:0] OP_UNUSED = 2'd3;

class timer_scoreboard;

   // Predicted timer state
   logic [15:0] div_q;
   logic [7:0]  counter_q;
   logic [7:0]  modulo_q;
   logic [2:0]  ctrl_q;
   logic        term_q;
   logic        msb_q;
   logic        reload_due_q;

   dart_pkg::result_type due_rsp[$];
   int                   errors;

   function new();
      errors = 0;
      clear_state();
   endfunction

   function void clear_state();
      div_q        = '0;
      counter_q    = '0;
      modulo_q     = '0;
      ctrl_q       = '0;
      term_q       = 1'b0;
      msb_q        = 1'b0;
      reload_due_q = 1'b0;
   endfunction

   // Enable ANDed with the divider tap chosen by the mode bits
   function logic counter_clock();
      logic tap;
      case (ctrl_q[1:0])
         2'd0: tap = div_q[7];
         2'd1: tap = div_q[1];
         2'd2: tap = div_q[3];
         default: tap = div_q[5];
      endcase
      return tap & ctrl_q[dart_pkg::CTRL_ENABLE];
   endfunction

   // Advance the model by one machine cycle and queue the response it yields
   function void note_request(dart_pkg::item_type rq);
      logic                 wr;
      logic                 count_wr;
      logic                 loaded;
      logic                 clk_now;
      dart_pkg::result_type want;
      wr       = (rq.operation == dart_pkg::OP_WRITE);
      count_wr = wr && (rq.reg_select == dart_pkg::REG_COUNTER);
      loaded   = 1'b0;
      want     = '0;

      if (wr && rq.reg_select == dart_pkg::REG_RELOAD)
         modulo_q = rq.write_data;
      if (wr && rq.reg_select == dart_pkg::REG_CONTROL)
         ctrl_q = rq.write_data[2:0];

      if (wr && rq.reg_select == dart_pkg::REG_DIVIDER)
         div_q = '0;
      else
         div_q = div_q + 16'd1;

      // A load (reload or counter write) wins over counting this cycle
      if (reload_due_q || count_wr) begin
         counter_q      = count_wr ? rq.write_data : modulo_q;
         want.timer_irq = reload_due_q;
         reload_due_q   = 1'b0;
         msb_q          = 1'b0;
         loaded         = 1'b1;
      end

      clk_now = counter_clock();
      if (!loaded) begin
         if (term_q && !clk_now)
            counter_q = counter_q + 8'd1;
         if (msb_q && !counter_q[7])
            reload_due_q = 1'b1;
         msb_q = counter_q[7];
      end
      term_q = clk_now;

      if (rq.operation == dart_pkg::OP_READ) begin
         case (rq.reg_select)
            dart_pkg::REG_DIVIDER: want.read_data =
               div_q[dart_pkg::DIV_READ_LSB +: dart_pkg::DATA_WIDTH];
            dart_pkg::REG_COUNTER: want.read_data = counter_q;
            dart_pkg::REG_RELOAD:  want.read_data = modulo_q;
            default:               want.read_data = {dart_pkg::CTRL_READ_FILL, ctrl_q};
         endcase
      end
      due_rsp.push_back(want);
   endfunction

   function void flag(string what);
      errors++;
      if (errors <= 10)
         $display("mismatch: %s", what);
   endfunction

   function void check_response(logic [15:0] tdata);
      dart_pkg::result_type seen;
      dart_pkg::result_type want;
      seen = tdata[8:0];
      if (due_rsp.size() == 0) begin
         flag($sformatf("response 0x%04h with no request outstanding", tdata));
         return;
      end
      want = due_rsp.pop_front();
      if (seen.read_data !== want.read_data)
         flag($sformatf("read_data expected 0x%02h got 0x%02h",
                        want.read_data, seen.read_data));
      if (seen.timer_irq !== want.timer_irq)
         flag($sformatf("timer_irq expected %0b got %0b",
                        want.timer_irq, seen.timer_irq));
   endfunction

   function int waiting();
      return due_rsp.size();
   endfunction

   function void close_out();
      if (due_rsp.size() != 0)
         flag($sformatf("%0d responses never arrived", due_rsp.size()));
   endfunction

endclass

module tb_divider_and_reload_timer;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] write_data
   logic [3:0]  req_tuser  = '0;   // [1:0] operation, [3:2] reg_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;         // [7:0] read_data, [8] timer_irq, [15:9] zero

   // Random idling on both channels; cleared for the tail of the run
   bit idle_on       = 1'b1;
   // Raised by the stimulus to ask the response side for one long hold-off
   bit long_hold_req = 1'b0;

   timer_scoreboard sb = new();

   divider_and_reload_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #(12 * 200000);
      $display("[divider_and_reload_timer] ERROR");
      $finish;
   end

   // Offer one request, optionally after a short gap, and hold it until taken.
   // The model advances at the edge where the request is accepted.
   task automatic send_request(input dart_pkg::item_type rq);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq.write_data;
      req_tuser  <= {rq.reg_select, rq.operation};
      do @(posedge clock); while (!req_tready);
      sb.note_request(rq);
   endtask

   task automatic issue(input logic [1:0] op, input logic [1:0] sel,
                        input logic [7:0] data);
      dart_pkg::item_type rq;
      rq.operation  = op;
      rq.reg_select = sel;
      rq.write_data = data;
      send_request(rq);
   endtask

   // Tick until the model sees an overflow, so the next request lands on the
   // reload cycle
   task automatic tick_to_overflow();
      int guard;
      guard = 0;
      while (!sb.reload_due_q && guard < 16) begin
         issue(dart_pkg::OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
         guard++;
      end
   endtask

   // Drop valid and hold until every outstanding response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.waiting() != 0);
   endtask

   // Bias toward values near the top so the counter overflows often
   function automatic logic [7:0] near_top();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'hF0, 8'hFF));
   endfunction

   function automatic dart_pkg::item_type random_request();
      dart_pkg::item_type rq;
      int                 pick;
      pick          = $urandom_range(0, 99);
      rq.operation  = dart_pkg::OP_TICK;
      rq.reg_select = 2'($urandom_range(0, 3));
      rq.write_data = 8'($urandom);
      if (sb.reload_due_q && $urandom_range(0, 2) == 0) begin
         // counter write on the reload cycle
         rq.operation  = dart_pkg::OP_WRITE;
         rq.reg_select = dart_pkg::REG_COUNTER;
         rq.write_data = near_top();
      end else if (pick < 45) begin
         if ($urandom_range(0, 9) == 0)
            rq.operation = OP_UNUSED;
      end else if (pick < 65) begin
         rq.operation = dart_pkg::OP_READ;
      end else if (pick < 75) begin
         rq.operation  = dart_pkg::OP_WRITE;
         rq.reg_select = dart_pkg::REG_COUNTER;
         rq.write_data = near_top();
      end else if (pick < 82) begin
         rq.operation  = dart_pkg::OP_WRITE;
         rq.reg_select = dart_pkg::REG_RELOAD;
         rq.write_data = near_top();
      end else if (pick < 93) begin
         rq.operation  = dart_pkg::OP_WRITE;
         rq.reg_select = dart_pkg::REG_CONTROL;
         // keep the timer enabled most of the time
         if ($urandom_range(0, 3) != 0)
            rq.write_data[dart_pkg::CTRL_ENABLE] = 1'b1;
      end else begin
         rq.operation  = dart_pkg::OP_WRITE;
         rq.reg_select = dart_pkg::REG_DIVIDER;
      end
      return rq;
   endfunction

   // Response side: random stalls in short bursts, plus one long hold-off on
   // request so the block backs up and stalls its input
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (40) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every accepted response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   initial begin
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset values, control masking, overflow and reload paths
      issue(dart_pkg::OP_READ,  dart_pkg::REG_COUNTER, 8'h00);
      issue(dart_pkg::OP_READ,  dart_pkg::REG_CONTROL, 8'hFF);
      // enable, fastest tap, high bits dropped
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_CONTROL, 8'hFD);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_COUNTER, 8'hFE);
      issue(dart_pkg::OP_READ,  dart_pkg::REG_CONTROL, 8'h00);
      tick_to_overflow();
      // counter write wins on the reload cycle
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_COUNTER, 8'h80);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_RELOAD,  8'h00);
      issue(dart_pkg::OP_READ,  dart_pkg::REG_COUNTER, 8'h00);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_DIVIDER, 8'hFF);   // clear; may add a count
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_CONTROL, 8'h02);   // disable; may add a count
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_CONTROL, 8'h07);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_CONTROL, 8'h05);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_RELOAD,  8'hFF);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_COUNTER, 8'hFF);
      tick_to_overflow();
      issue(dart_pkg::OP_READ,  dart_pkg::REG_COUNTER, 8'h00);   // read on the reload cycle
      issue(OP_UNUSED,          dart_pkg::REG_CONTROL, 8'hFF);
      issue(dart_pkg::OP_READ,  dart_pkg::REG_DIVIDER, 8'h00);
      issue(dart_pkg::OP_WRITE, dart_pkg::REG_CONTROL, 8'h04);   // slowest tap

      // Random: mostly timer traffic that keeps the counter overflowing
      for (n = 0; n < 400; n++) begin
         if (n == 100)
            drain();
         if (n == 200)
            long_hold_req = 1'b1;
         if (n == 340)
            idle_on = 1'b0;
         send_request(random_request());
      end

      drain();
      repeat (8) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0)
         $display("[divider_and_reload_timer] OK");
      else
         $display("[divider_and_reload_timer] ERROR");
      $finish;
   end

endmodule
